// ===== rtl/lmsp_pkg.sv =====
// Shared types, constants and state codes of the linear move step planner.
package lmsp_pkg;

    localparam int AXES       = 3;
    localparam int MM_W       = 24;
    localparam int SPM_W      = 24;
    localparam int TICK_W     = 27;
    localparam int POS_W      = 32;
    localparam int STEPS_W    = 31;
    localparam int PERIOD_W   = 32;
    localparam int SQ_W       = 60;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;

    localparam logic [CFG_IDX_W-1:0] CFG_SPM_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPM_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPM_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK  = 2'd3;

    localparam logic KIND_MOVE   = 1'b0;
    localparam logic KIND_ORIGIN = 1'b1;

    localparam logic [SPM_W-1:0]  SPM_RESET  = 24'd25600;
    localparam logic [TICK_W-1:0] TICK_RESET = 27'd1000000;
    localparam logic signed [42:0] DELTA_LIMIT = 43'sd1073741823;
    localparam logic [STEPS_W-1:0]  STEPS_MAX  = {STEPS_W{1'b1}};
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = {PERIOD_W{1'b1}};

    typedef struct packed {
        logic                    kind;
        logic signed [MM_W-1:0]  target_x;
        logic signed [MM_W-1:0]  target_y;
        logic signed [MM_W-1:0]  target_z;
        logic [23:0]             speed;
    } lmsp_in_t;

    typedef struct packed {
        logic                dir_x;
        logic [STEPS_W-1:0]  steps_x;
        logic [PERIOD_W-1:0] period_x;
        logic                dir_y;
        logic [STEPS_W-1:0]  steps_y;
        logic [PERIOD_W-1:0] period_y;
        logic                dir_z;
        logic [STEPS_W-1:0]  steps_z;
        logic [PERIOD_W-1:0] period_z;
    } lmsp_out_t;

    typedef struct packed {
        logic start_a;
        logic start_b;
    } lmsp_lane_ctl_t;

    typedef struct packed {
        logic                   sq_valid;
        logic                   per_valid;
        logic [SQ_W-1:0]        sq;
        logic signed [POS_W-1:0] ts;
        logic                   dir;
        logic [STEPS_W-1:0]     steps;
        logic [PERIOD_W-1:0]    period;
    } lmsp_lane_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_LANE,
        ST_SUM,
        ST_ROOT,
        ST_MUL,
        ST_TDIV,
        ST_PSTART,
        ST_PER,
        ST_OUT
    } lmsp_state_t;

endpackage

// ===== rtl/lmsp_div.sv =====
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
module lmsp_div import lmsp_pkg::*; #(
    parameter int NW = 64,
    parameter int DW = 33
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [NW-1:0] q_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_sub;
    logic          ge;

    assign rem_sh  = {rem_reg, q_reg[NW-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= CW'(NW);
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == CW'(1));
            if (cnt_reg != '0) cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (cnt_reg != '0) begin
            q_reg   <= {q_reg[NW-2:0], ge};
            rem_reg <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;
endmodule

// ===== rtl/lmsp_sqrt.sv =====
// Iterative floor square root of a 64-bit value, one result bit per cycle.
module lmsp_sqrt import lmsp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] value,
    output logic        done,
    output logic [31:0] root
);
    logic [5:0]  cnt_reg;
    logic        done_reg;
    logic [63:0] v_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= 6'd32;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == 6'd1);
            if (cnt_reg != '0) cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg   <= value;
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end else if (cnt_reg != '0) begin
            if (v_reg >= trial) begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];
endmodule

// ===== rtl/lmsp_lane.sv =====
// One axis lane: target steps, position in mm, squared delta and step period.
module lmsp_lane import lmsp_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lmsp_lane_ctl_t           ctl,
    input  logic signed [MM_W-1:0]   tgt,
    input  logic [SPM_W-1:0]         spm,
    input  logic signed [POS_W-1:0]  pos,
    input  logic [63:0]              ticks,
    output lmsp_lane_res_t           res
);
    logic signed [48:0] prod_reg;
    logic signed [48:0] prod_bias;
    logic signed [POS_W-1:0] ts;
    logic        phase_b_reg;
    logic        pos_neg_reg;
    logic        spm_zero_reg;
    logic        a_valid_reg;
    logic        sq_valid_reg;
    logic        per_valid_reg;
    logic [29:0] a_reg;
    logic [SQ_W-1:0] sq_reg;
    logic [32:0] mag_reg;
    logic        dir_reg;
    logic        moving_reg;
    logic [PERIOD_W-1:0] period_reg;

    logic [31:0] pos_abs;
    logic        div_start;
    logic [63:0] div_num;
    logic [32:0] div_den;
    logic        div_done;
    logic [63:0] div_quo;

    logic signed [42:0] pos_mm;
    logic signed [42:0] delta;
    logic signed [42:0] delta_sat;
    logic signed [32:0] n_full;

    assign prod_bias = prod_reg + (prod_reg[48] ? 49'sd65535 : 49'sd0);
    assign ts        = prod_bias[47:16];
    assign pos_abs   = pos[POS_W-1] ? 32'(-pos) : 32'(pos);

    assign div_start = ctl.start_a | ctl.start_b;
    assign div_num   = ctl.start_b ? ticks : {24'd0, pos_abs, 8'd0};
    assign div_den   = ctl.start_b ? mag_reg : {9'd0, spm};

    lmsp_div #(.NW(64), .DW(33)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // Truncating signed division: divide magnitudes, then restore the sign.
    always_comb begin
        if (spm_zero_reg) pos_mm = '0;
        else if (pos_neg_reg) pos_mm = -$signed({3'b000, div_quo[39:0]});
        else pos_mm = $signed({3'b000, div_quo[39:0]});
        delta = 43'(tgt) - pos_mm;
        if (delta > DELTA_LIMIT) delta_sat = DELTA_LIMIT;
        else if (delta < -DELTA_LIMIT) delta_sat = -DELTA_LIMIT;
        else delta_sat = delta;
        n_full = 33'(ts) - 33'(pos);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_b_reg   <= 1'b0;
            a_valid_reg   <= 1'b0;
            sq_valid_reg  <= 1'b0;
            per_valid_reg <= 1'b0;
        end else begin
            if (ctl.start_a) phase_b_reg <= 1'b0;
            else if (ctl.start_b) phase_b_reg <= 1'b1;
            a_valid_reg   <= div_done & ~phase_b_reg;
            sq_valid_reg  <= a_valid_reg;
            per_valid_reg <= div_done & phase_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start_a) begin
            prod_reg     <= tgt * $signed({1'b0, spm});
            pos_neg_reg  <= pos[POS_W-1];
            spm_zero_reg <= (spm == '0);
        end
        if (div_done && !phase_b_reg) begin
            a_reg      <= delta_sat[42] ? 30'(-delta_sat) : 30'(delta_sat);
            dir_reg    <= n_full[32];
            moving_reg <= (n_full != '0);
            mag_reg    <= n_full[32] ? 33'(-n_full) : 33'(n_full);
        end
        if (a_valid_reg) sq_reg <= a_reg * a_reg;
        if (div_done && phase_b_reg) begin
            if (!moving_reg) period_reg <= '0;
            else if (div_quo[63:32] != '0) period_reg <= PERIOD_MAX;
            else if (div_quo[31:0] == '0) period_reg <= 32'd1;
            else period_reg <= div_quo[31:0];
        end
    end

    always_comb begin
        res.sq_valid  = sq_valid_reg;
        res.per_valid = per_valid_reg;
        res.sq        = sq_reg;
        res.ts        = ts;
        res.dir       = moving_reg & dir_reg;
        if (!moving_reg) res.steps = '0;
        else if (mag_reg[32:31] != 2'b00) res.steps = STEPS_MAX;
        else res.steps = mag_reg[30:0];
        res.period    = period_reg;
    end
endmodule

// ===== rtl/linear_move_step_planner.sv =====
// Top level of the three-axis linear move step planner.
//
// Input beats (s_valid/s_ready, payload s_data) carry a kind bit, a target per
// axis in mm (Q.8) and a speed (Q.8 mm/s). A set-origin beat loads the axis
// positions and emits nothing. A move beat with nonzero distance emits one
// result beat (m_valid/m_ready, payload m_data) with direction, step count and
// step period per axis, then advances the positions.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
// taken: steps per mm for x, y, z, then the tick rate.
//
// One input beat is handled at a time. The axis lanes run their position
// divider, then the shared root runs, then the tick divider (skipped at zero
// speed) and the lane period dividers lead to a result beat; a set-origin beat
// ends after the lane position dividers. These serial dividers set the rate.
// A finished result sits in the output register; the next input beat is
// taken while it waits. If the receiver stalls a second result, the block
// holds in its output state until the register frees.
// Reset clears positions to the origin and restores register defaults.
module linear_move_step_planner import lmsp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lmsp_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lmsp_out_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    lmsp_state_t state_reg, state_next;

    lmsp_in_t                 in_reg;
    logic [SPM_W-1:0]         spm_reg [AXES];
    logic [TICK_W-1:0]        tick_reg;
    logic signed [POS_W-1:0]  pos_reg [AXES];
    logic [63:0]              sum_reg;
    logic [58:0]              mul_reg;
    logic [63:0]              ticks_reg;
    logic                     m_valid_reg;
    lmsp_out_t                m_data_reg;

    logic signed [MM_W-1:0]   tgt [AXES];
    lmsp_lane_ctl_t           lane_ctl;
    lmsp_lane_res_t           lane_res [AXES];
    logic [63:0]              sum_next;

    logic        sqrt_start, sqrt_done;
    logic [31:0] sqrt_root;
    logic        tdiv_start, tdiv_done;
    logic [63:0] tdiv_quo;

    logic s_accept;
    logic load_org, load_sum, load_dist, load_ticks, load_ticks_max, load_out;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid & s_ready;
    assign cfg_ready = 1'b1;

    assign tgt[0] = in_reg.target_x;
    assign tgt[1] = in_reg.target_y;
    assign tgt[2] = in_reg.target_z;

    // One lane per axis; all lanes run in lockstep, so lane 0 paces the FSM.
    for (genvar i = 0; i < AXES; i++) begin : g_lane
        lmsp_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (lane_ctl),
            .tgt     (tgt[i]),
            .spm     (spm_reg[i]),
            .pos     (pos_reg[i]),
            .ticks   (ticks_reg),
            .res     (lane_res[i])
        );
    end

    // Merge: sum the squared deltas of all lanes.
    always_comb begin
        sum_next = '0;
        for (int i = 0; i < AXES; i++) sum_next = sum_next + 64'(lane_res[i].sq);
    end

    lmsp_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .value   (sum_reg),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    lmsp_div #(.NW(64), .DW(24)) u_tdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (tdiv_start),
        .num     ({5'd0, mul_reg}),
        .den     (in_reg.speed),
        .done    (tdiv_done),
        .quo     (tdiv_quo)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_accept) state_next = ST_START;
            ST_START:  state_next = ST_LANE;
            ST_LANE: begin
                if (lane_res[0].sq_valid)
                    state_next = (in_reg.kind == KIND_ORIGIN) ? ST_IDLE : ST_SUM;
            end
            ST_SUM:    state_next = ST_ROOT;
            ST_ROOT: begin
                if (sqrt_done) state_next = (sqrt_root == '0) ? ST_IDLE : ST_MUL;
            end
            ST_MUL:    state_next = (in_reg.speed == '0) ? ST_PSTART : ST_TDIV;
            ST_TDIV:   if (tdiv_done) state_next = ST_PSTART;
            ST_PSTART: state_next = ST_PER;
            ST_PER:    if (lane_res[0].per_valid) state_next = ST_OUT;
            ST_OUT:    if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control strobes.
    always_comb begin
        lane_ctl.start_a = (state_reg == ST_START);
        lane_ctl.start_b = (state_reg == ST_PSTART);
        sqrt_start       = (state_reg == ST_SUM);
        tdiv_start       = (state_reg == ST_MUL) && (in_reg.speed != '0);
        load_ticks_max   = (state_reg == ST_MUL) && (in_reg.speed == '0);
        load_ticks       = (state_reg == ST_TDIV) && tdiv_done;
        load_org  = (state_reg == ST_LANE) && lane_res[0].sq_valid
                    && (in_reg.kind == KIND_ORIGIN);
        load_sum  = (state_reg == ST_LANE) && lane_res[0].sq_valid
                    && (in_reg.kind == KIND_MOVE);
        load_dist = (state_reg == ST_ROOT) && sqrt_done;
        load_out  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            tick_reg    <= TICK_RESET;
            for (int i = 0; i < AXES; i++) begin
                spm_reg[i] <= SPM_RESET;
                pos_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (load_out) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_SPM_X: spm_reg[0] <= cfg_data[SPM_W-1:0];
                    CFG_SPM_Y: spm_reg[1] <= cfg_data[SPM_W-1:0];
                    CFG_SPM_Z: spm_reg[2] <= cfg_data[SPM_W-1:0];
                    CFG_TICK:  tick_reg   <= cfg_data;
                    default:   ;
                endcase
            end
            // Advance every axis to its target; idle axes already sit there.
            if (load_org || load_out) begin
                for (int i = 0; i < AXES; i++) pos_reg[i] <= lane_res[i].ts;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) in_reg <= s_data;
        if (load_sum) sum_reg <= sum_next;
        // Form distance times tick rate as the root finishes, ready for the divider.
        if (load_dist) mul_reg <= 59'(sqrt_root * tick_reg);
        if (load_ticks_max) ticks_reg <= '1;
        else if (load_ticks) ticks_reg <= tdiv_quo;
        if (load_out) begin
            m_data_reg.dir_x    <= lane_res[0].dir;
            m_data_reg.steps_x  <= lane_res[0].steps;
            m_data_reg.period_x <= lane_res[0].period;
            m_data_reg.dir_y    <= lane_res[1].dir;
            m_data_reg.steps_y  <= lane_res[1].steps;
            m_data_reg.period_y <= lane_res[1].period;
            m_data_reg.dir_z    <= lane_res[2].dir;
            m_data_reg.steps_z  <= lane_res[2].steps;
            m_data_reg.period_z <= lane_res[2].period;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // An axis reports a period exactly when it steps.
    a_period_iff_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (((m_data.period_x == '0) == (m_data.steps_x == '0))
                  && ((m_data.period_y == '0) == (m_data.steps_y == '0))
                  && ((m_data.period_z == '0) == (m_data.steps_z == '0))))
        else $error("period and step count disagree on idle axis");

    // A new result beat appears only from the output state.
    a_out_from_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_OUT))
        else $error("result beat raised outside output state");

    // The period result of lane 0 never pulses while the block is idle.
    a_lane_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !(lane_res[0].per_valid))
        else $error("lane period result while idle");
endmodule
